// ===== hw/rtl/nat64_checksum_incremental_update_assert.svh =====
// Assertion helpers used by the checksum update RTL.
`ifndef NAT64_CHECKSUM_INCREMENTAL_UPDATE_ASSERT_SVH
`define NAT64_CHECKSUM_INCREMENTAL_UPDATE_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define NCU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ncu assertion failed");

// Condition that must never be true outside reset.
`define NCU_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("ncu forbidden condition seen");

`endif

// ===== hw/rtl/ncu_pkg.sv =====
package ncu_pkg;

  // Translation direction
  typedef enum logic {
    CMD_V6_TO_V4 = 1'b0,
    CMD_V4_TO_V6 = 1'b1
  } cmd_e;

  localparam int unsigned WORD_W        = 16;
  localparam int unsigned NUM_OPS       = 24;  // 22 real word steps, 2 no-op pads
  localparam int unsigned OPS_PER_STAGE = 4;
  localparam int unsigned NUM_STAGES    = NUM_OPS / OPS_PER_STAGE;
  localparam int unsigned LAST          = NUM_STAGES - 1;

  typedef logic [WORD_W-1:0] word_t;

  // One word step: add with end-around carry or subtract with end-around borrow
  typedef struct packed {
    logic  is_add;
    word_t word;
  } op_t;

  // Pipeline payload: running sum and the step list
  typedef struct packed {
    word_t                     s;
    op_t [NUM_OPS-1:0]         ops;
  } pipe_t;

  function automatic word_t add_word(word_t s, word_t w);
    logic [WORD_W:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[WORD_W] ? (t[WORD_W-1:0] + word_t'(1)) : t[WORD_W-1:0];
  endfunction

  function automatic word_t sub_word(word_t s, word_t w);
    return (w > s) ? (s - w - word_t'(1)) : (s - w);
  endfunction

  function automatic word_t apply_op(word_t s, op_t op);
    return op.is_add ? add_word(s, op.word) : sub_word(s, op.word);
  endfunction

endpackage

// ===== hw/rtl/ncu_stage.sv =====
// Four dependent word steps on the running sum, lowest op first.
module ncu_stage import ncu_pkg::*; (
  input  word_t                     s_i,
  input  op_t [OPS_PER_STAGE-1:0]   ops_i,
  output word_t                     s_o
);

  word_t chain [OPS_PER_STAGE+1];

  always_comb begin
    chain[0] = s_i;
    for (int i = 0; i < OPS_PER_STAGE; i++) begin
      chain[i+1] = apply_op(chain[i], ops_i[i]);
    end
  end

  assign s_o = chain[OPS_PER_STAGE];

endmodule

// ===== hw/rtl/nat64_checksum_incremental_update.sv =====
// Channel | handshake          | payload
// --------+--------------------+---------------------------------------------
// input   | valid_i / stall_o  | command_i, old_checksum_i, v6_*_i, v4_*_i,
//         |                    | old_port_value_i, new_port_value_i
// output  | valid_o / stall_i  | new_checksum_o
//
// One transaction per cycle sustained while stall_i stays low; each result
// passes through every pipeline stage, each stage running four word steps.
// Reset clears only the stage valid bits; data registers are not reset.
// A stage holds while the one after it is full and held, so bubbles collapse
// and stall_o rises only once every stage holds a transaction.
module nat64_checksum_incremental_update import ncu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        command_i,
  input  logic [15:0] old_checksum_i,
  input  logic [63:0] v6_src_hi_i,
  input  logic [63:0] v6_src_lo_i,
  input  logic [63:0] v6_dst_hi_i,
  input  logic [63:0] v6_dst_lo_i,
  input  logic [31:0] v4_src_i,
  input  logic [31:0] v4_dst_i,
  input  logic [15:0] old_port_value_i,
  input  logic [15:0] new_port_value_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [15:0] new_checksum_o
);

`include "nat64_checksum_incremental_update_assert.svh"

  word_t                 v6w [16];
  word_t                 v4w [4];
  op_t [NUM_OPS-1:0]     dec_ops;
  pipe_t                 dec_pipe;

  pipe_t                 pipe_q [NUM_STAGES];
  pipe_t                 pipe_in [NUM_STAGES];
  pipe_t                 pipe_d [NUM_STAGES];
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] valid_in;
  logic [NUM_STAGES:0]   rdy;

  // Split addresses into big-endian words and build the step list
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      v6w[j]      = v6_src_hi_i[16*(3-j) +: 16];
      v6w[4 + j]  = v6_src_lo_i[16*(3-j) +: 16];
      v6w[8 + j]  = v6_dst_hi_i[16*(3-j) +: 16];
      v6w[12 + j] = v6_dst_lo_i[16*(3-j) +: 16];
    end
    v4w[0] = v4_src_i[31:16];
    v4w[1] = v4_src_i[15:0];
    v4w[2] = v4_dst_i[31:16];
    v4w[3] = v4_dst_i[15:0];

    // pads: adding zero leaves the sum unchanged
    for (int i = 0; i < NUM_OPS; i++) begin
      dec_ops[i].is_add = 1'b1;
      dec_ops[i].word   = '0;
    end

    unique case (cmd_e'(command_i))
      CMD_V6_TO_V4: begin
        for (int j = 0; j < 16; j++) begin
          dec_ops[j].is_add = 1'b0;
          dec_ops[j].word   = v6w[j];
        end
        dec_ops[16].is_add = 1'b0;
        dec_ops[16].word   = old_port_value_i;
        for (int j = 0; j < 4; j++) begin
          dec_ops[17 + j].word = v4w[j];
        end
      end
      CMD_V4_TO_V6: begin
        for (int j = 0; j < 4; j++) begin
          dec_ops[j].is_add = 1'b0;
          dec_ops[j].word   = v4w[j];
        end
        dec_ops[4].is_add = 1'b0;
        dec_ops[4].word   = old_port_value_i;
        for (int j = 0; j < 16; j++) begin
          dec_ops[5 + j].word = v6w[j];
        end
      end
      default: begin
      end
    endcase
    dec_ops[21].word = new_port_value_i;

    dec_pipe.s   = ~old_checksum_i;
    dec_pipe.ops = dec_ops;
  end

  // Ready chain: a stage may load when empty or when it drains this cycle
  always_comb begin
    rdy[NUM_STAGES] = !stall_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end
  assign stall_o = !rdy[0];

  // Stage datapath
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign pipe_in[k]  = dec_pipe;
      assign valid_in[k] = valid_i;
    end else begin : g_next
      assign pipe_in[k]  = pipe_q[k-1];
      assign valid_in[k] = valid_q[k-1];
    end

    ncu_stage u_stage (
      .s_i   (pipe_in[k].s),
      .ops_i (pipe_in[k].ops[k*OPS_PER_STAGE +: OPS_PER_STAGE]),
      .s_o   (pipe_d[k].s)
    );
    assign pipe_d[k].ops = pipe_in[k].ops;

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= valid_in[k];
      end
    end

    // payload
    always_ff @(posedge clk_i) begin
      if (rdy[k] && valid_in[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign valid_o        = valid_q[LAST];
  assign new_checksum_o = ~pipe_q[LAST].s;

  // Stall only when every stage is occupied
  `NCU_ASSERT(a_stall_full, stall_o |-> (&valid_q))
  // A held first stage keeps its sum
  `NCU_ASSERT(a_hold_first, (valid_q[0] && !rdy[1]) |=> (valid_q[0] && $stable(pipe_q[0].s)))
  // A transaction leaving the first stage lands in the second
  `NCU_ASSERT(a_move_first, (valid_q[0] && rdy[1]) |=> valid_q[1])
  // Input stall only follows a stalled output
  `NCU_ASSERT_NEVER(a_stall_source, stall_o && !stall_i)
  // Output drains when nothing follows it
  `NCU_ASSERT(a_empty_after, (valid_o && !stall_i && !valid_q[LAST-1]) |=> !valid_o)

endmodule

// ===== dv/testbench.sv =====
module testbench import ncu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_PACKETS = 2000;
  localparam int unsigned MAX_WAIT       = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned REPORT_LIMIT   = 10;

  // One header translation request
  typedef struct {
    cmd_e        command;
    logic [15:0] old_checksum;
    logic [63:0] v6_src_hi;
    logic [63:0] v6_src_lo;
    logic [63:0] v6_dst_hi;
    logic [63:0] v6_dst_lo;
    logic [31:0] v4_src;
    logic [31:0] v4_dst;
    logic [15:0] port_before;
    logic [15:0] port_after;
  } xlat_req_t;

  // Predicts the rewritten checksum for each accepted header and checks results in order
  class checksum_ledger;
    logic [15:0] expected_q[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
    endfunction

    // Ones-complement subtract: a borrow wraps around as an extra decrement
    static function logic [15:0] ones_sub(logic [15:0] s, logic [15:0] w);
      logic [31:0] d;
      d = {16'h0, s} + 32'h0001_0000 - {16'h0, w};
      if (w > s) d = d - 32'd1;
      return d[15:0];
    endfunction

    // Ones-complement add: a carry wraps around as an extra increment
    static function logic [15:0] ones_add(logic [15:0] s, logic [15:0] w);
      logic [31:0] t;
      t = {16'h0, s} + {16'h0, w};
      if (t > 32'h0000_ffff) t = t + 32'd1;
      return t[15:0];
    endfunction

    // Walk count words, most significant word first
    static function logic [15:0] fold_words(logic [15:0] s, logic [255:0] words,
                                            int count, bit add);
      logic [15:0] w;
      for (int k = count - 1; k >= 0; k--) begin
        w = words[k*16 +: 16];
        s = add ? ones_add(s, w) : ones_sub(s, w);
      end
      return s;
    endfunction

    static function logic [15:0] predict_checksum(xlat_req_t r);
      logic [255:0] v6_words;
      logic [255:0] v4_words;
      logic [15:0]  s;
      v6_words = {r.v6_src_hi, r.v6_src_lo, r.v6_dst_hi, r.v6_dst_lo};
      v4_words = {192'h0, r.v4_src, r.v4_dst};
      s = ~r.old_checksum;
      // removed side first: addresses then old port; added side after
      if (r.command == CMD_V6_TO_V4) begin
        s = fold_words(s, v6_words, 16, 1'b0);
        s = ones_sub(s, r.port_before);
        s = fold_words(s, v4_words, 4, 1'b1);
      end else begin
        s = fold_words(s, v4_words, 4, 1'b0);
        s = ones_sub(s, r.port_before);
        s = fold_words(s, v6_words, 16, 1'b1);
      end
      s = ones_add(s, r.port_after);
      return ~s;
    endfunction

    function void note_packet(xlat_req_t r);
      expected_q.push_back(predict_checksum(r));
    endfunction

    function void check_checksum(logic [15:0] got);
      logic [15:0] want;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("checksum result %h with no transaction outstanding", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("new_checksum mismatch: expected %h, got %h", want, got);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic        command_i;
  logic [15:0] old_checksum_i;
  logic [63:0] v6_src_hi_i;
  logic [63:0] v6_src_lo_i;
  logic [63:0] v6_dst_hi_i;
  logic [63:0] v6_dst_lo_i;
  logic [31:0] v4_src_i;
  logic [31:0] v4_dst_i;
  logic [15:0] old_port_value_i;
  logic [15:0] new_port_value_i;
  logic        valid_o;
  logic        stall_i;
  logic [15:0] new_checksum_o;

  checksum_ledger ledger = new();

  nat64_checksum_incremental_update dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .command_i        (command_i),
    .old_checksum_i   (old_checksum_i),
    .v6_src_hi_i      (v6_src_hi_i),
    .v6_src_lo_i      (v6_src_lo_i),
    .v6_dst_hi_i      (v6_dst_hi_i),
    .v6_dst_lo_i      (v6_dst_lo_i),
    .v4_src_i         (v4_src_i),
    .v4_dst_i         (v4_dst_i),
    .old_port_value_i (old_port_value_i),
    .new_port_value_i (new_port_value_i),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .new_checksum_o   (new_checksum_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Field value biased toward zero, all ones and single set bits
  function automatic logic [63:0] pick_value(int unsigned bits);
    logic [63:0] mask;
    logic [63:0] v;
    mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1 << $urandom_range(0, bits - 1);
      default: v = {$urandom, $urandom};
    endcase
    return v & mask;
  endfunction

  function automatic xlat_req_t random_packet();
    xlat_req_t r;
    r.command      = cmd_e'($urandom_range(0, 1));
    r.old_checksum = 16'(pick_value(16));
    r.v4_src       = 32'(pick_value(32));
    r.v4_dst       = 32'(pick_value(32));
    r.port_before  = 16'(pick_value(16));
    r.port_after   = 16'(pick_value(16));
    // a third of the headers use the well-known prefix with the IPv4 address embedded
    if ($urandom_range(0, 2) == 0) begin
      r.v6_src_hi = 64'h0064_ff9b_0000_0000;
      r.v6_src_lo = {32'h0, r.v4_src};
      r.v6_dst_hi = 64'h0064_ff9b_0000_0000;
      r.v6_dst_lo = {32'h0, r.v4_dst};
    end else begin
      r.v6_src_hi = pick_value(64);
      r.v6_src_lo = pick_value(64);
      r.v6_dst_hi = pick_value(64);
      r.v6_dst_lo = pick_value(64);
    end
    return r;
  endfunction

  // Present one transaction, hold it until accepted
  task automatic send_packet(input xlat_req_t r, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command_i        <= r.command;
    old_checksum_i   <= r.old_checksum;
    v6_src_hi_i      <= r.v6_src_hi;
    v6_src_lo_i      <= r.v6_src_lo;
    v6_dst_hi_i      <= r.v6_dst_hi;
    v6_dst_lo_i      <= r.v6_dst_lo;
    v4_src_i         <= r.v4_src;
    v4_dst_i         <= r.v4_dst;
    old_port_value_i <= r.port_before;
    new_port_value_i <= r.port_after;
    valid_i          <= 1'b1;
    do @(posedge clk_i); while (stall_o !== 1'b0);
    ledger.note_packet(r);
  endtask

  // Same fill for all IPv6 halves and for both IPv4 addresses
  task automatic send_directed(input cmd_e c, input logic [15:0] cks,
                               input logic [63:0] v6, input logic [31:0] v4,
                               input logic [15:0] port_before,
                               input logic [15:0] port_after);
    xlat_req_t r;
    r.command      = c;
    r.old_checksum = cks;
    r.v6_src_hi    = v6;
    r.v6_src_lo    = v6;
    r.v6_dst_hi    = v6;
    r.v6_dst_lo    = v6;
    r.v4_src       = v4;
    r.v4_dst       = v4;
    r.port_before  = port_before;
    r.port_after   = port_after;
    send_packet(r, 1'b0);
  endtask

  // Stimulus and end of test
  initial begin
    rst_ni           <= 1'b0;
    valid_i          <= 1'b0;
    command_i        <= 1'b0;
    old_checksum_i   <= '0;
    v6_src_hi_i      <= '0;
    v6_src_lo_i      <= '0;
    v6_dst_hi_i      <= '0;
    v6_dst_lo_i      <= '0;
    v4_src_i         <= '0;
    v4_dst_i         <= '0;
    old_port_value_i <= '0;
    new_port_value_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all zero and all ones fields, both directions
    send_directed(CMD_V6_TO_V4, 16'h0000, '0, '0, 16'h0000, 16'h0000);
    send_directed(CMD_V4_TO_V6, 16'h0000, '0, '0, 16'h0000, 16'h0000);
    send_directed(CMD_V6_TO_V4, 16'hffff, '1, '1, 16'hffff, 16'hffff);
    send_directed(CMD_V4_TO_V6, 16'hffff, '1, '1, 16'hffff, 16'hffff);
    send_directed(CMD_V6_TO_V4, 16'h0000, '1, '1, 16'hffff, 16'hffff);
    send_directed(CMD_V4_TO_V6, 16'hffff, '0, '0, 16'h0000, 16'h0000);
    // running sum at zero, removed word larger: borrow wraps
    send_directed(CMD_V6_TO_V4, 16'hffff, '0, '0, 16'h0001, 16'h0000);
    send_directed(CMD_V4_TO_V6, 16'hffff, '0, '0, 16'h8000, 16'h0000);
    // removed word equal to the running sum gives zero
    send_directed(CMD_V6_TO_V4, 16'h1234, 64'hedcb_edcb_edcb_edcb, '0, 16'h0, 16'h0);
    send_directed(CMD_V4_TO_V6, 16'h1234, '0, 32'hedcb_edcb, 16'h0, 16'h0);
    // added words overflow: carry wraps
    send_directed(CMD_V6_TO_V4, 16'hffff, '0, 32'hffff_ffff, 16'h0000, 16'hffff);
    send_directed(CMD_V4_TO_V6, 16'h0000, 64'h8000_8000_8000_8000, '0, 16'h0, 16'h8000);
    // alternating bit patterns
    send_directed(CMD_V6_TO_V4, 16'haaaa, 64'h5555_5555_5555_5555, 32'haaaa_aaaa,
                  16'h5555, 16'haaaa);
    send_directed(CMD_V4_TO_V6, 16'h5555, 64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555,
                  16'haaaa, 16'h5555);
    // removed and added words with equal sums
    send_directed(CMD_V6_TO_V4, 16'h3c5a, 64'h0001_0001_0001_0001, 32'h0004_0004,
                  16'h0050, 16'h0050);

    for (int i = 0; i < RANDOM_PACKETS; i++)
      send_packet(random_packet(), ((i / 150) % 4) == 2);
    valid_i <= 1'b0;

    while (ledger.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ledger.fail_count == 0 && ledger.expected_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Result side: random stall before each transaction, with stall-free stretches
  initial begin
    int unsigned hold;
    int unsigned seen;
    seen = 0;
    stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      hold = (((seen / 170) % 4) == 3) ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold > 0) begin
        stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (valid_o !== 1'b1);
      ledger.check_checksum(new_checksum_o);
      seen++;
    end
  end

  // Watchdog: too long without a transaction on either side
  initial begin
    int unsigned idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((valid_i === 1'b1 && stall_o === 1'b0) || (valid_o === 1'b1 && stall_i === 1'b0))
        idle = 0;
      else
        idle++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
